// ===== design/cpem_pkg.sv =====
// Shared types and codes for the calorimeter pulse event monitor.
`timescale 1ns / 1ps
`default_nettype none

package cpem_pkg;

	localparam int MODE_W = 2;
	localparam int SECTION_W = 3;
	localparam int SLICE_W = 3;
	localparam int ADC_W = 8;
	localparam int CHARGE_W = 24;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 30;
	localparam int PULSE_THR_W = 30;

	localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLOSE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ = 2'd2;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	localparam logic [SECTION_W-1:0] SECTION_FIRST = 3'd1;
	localparam logic [SECTION_W-1:0] SECTION_SECOND = 3'd2;

	localparam logic [CFG_INDEX_W-1:0] CFG_ADC_THRESHOLD = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_THRESHOLD = 1'd1;

	localparam logic [ADC_W-1:0] ADC_THRESHOLD_RESET = 8'd10;
	localparam logic [PULSE_THR_W-1:0] PULSE_THRESHOLD_RESET = 30'd160;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_CLOSE = 2'd1,
		OP_READ = 2'd2
	} op_kind_t;

	typedef struct packed {
		op_kind_t kind;
		logic side_plus;
		logic counted;
		logic adc_high;
		logic slice_ok;
		logic [SLICE_W-1:0] slice;
		logic [ADC_W-1:0] adc;
		logic signed [CHARGE_W-1:0] charge;
	} op_t;

endpackage

`default_nettype wire

// ===== design/cpem_front.sv =====
// Front end: accepts input words, drops those with no effect and classifies the rest.
`timescale 1ns / 1ps
`default_nettype none

module cpem_front #(
	parameter int SLICES = 6
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [cpem_pkg::CFG_INDEX_W-1:0] cfg_index,
	input wire logic [cpem_pkg::CFG_DATA_W-1:0] cfg_data,
	input wire logic in_valid,
	input wire logic [cpem_pkg::MODE_W-1:0] mode,
	input wire logic side_plus,
	input wire logic [cpem_pkg::SECTION_W-1:0] section,
	input wire logic [cpem_pkg::SLICE_W-1:0] slice,
	input wire logic [cpem_pkg::ADC_W-1:0] adc,
	input wire logic signed [cpem_pkg::CHARGE_W-1:0] charge,
	output logic push_valid,
	output cpem_pkg::op_t push_op
);

	logic [cpem_pkg::ADC_W-1:0] adc_threshold_q;
	logic slice_ok;
	logic keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adc_threshold_q <= cpem_pkg::ADC_THRESHOLD_RESET;
		end else if (cfg_we && cfg_index == cpem_pkg::CFG_ADC_THRESHOLD) begin
			adc_threshold_q <= cfg_data[cpem_pkg::ADC_W-1:0];
		end
	end

	assign slice_ok = 32'(slice) < SLICES;

	always_comb begin
		push_op.kind = cpem_pkg::OP_SAMPLE;
		keep = 1'b0;
		unique case (mode)
			cpem_pkg::MODE_SAMPLE: begin
				push_op.kind = cpem_pkg::OP_SAMPLE;
				keep = slice_ok;
			end
			cpem_pkg::MODE_CLOSE: begin
				push_op.kind = cpem_pkg::OP_CLOSE;
				keep = 1'b1;
			end
			cpem_pkg::MODE_READ: begin
				push_op.kind = cpem_pkg::OP_READ;
				keep = 1'b1;
			end
			cpem_pkg::MODE_UNUSED: begin
				push_op.kind = cpem_pkg::OP_SAMPLE;
				keep = 1'b0;
			end
		endcase
		push_op.side_plus = side_plus;
		push_op.counted = section == cpem_pkg::SECTION_FIRST ||
			section == cpem_pkg::SECTION_SECOND;
		push_op.adc_high = adc > adc_threshold_q;
		push_op.slice_ok = slice_ok;
		push_op.slice = slice;
		push_op.adc = adc;
		push_op.charge = charge;
	end

	assign push_valid = in_valid && keep;

endmodule

`default_nettype wire

// ===== design/cpem_queue.sv =====
// Short queue of classified operations between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module cpem_queue #(
	parameter int DEPTH = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push_valid,
	input wire cpem_pkg::op_t push_op,
	output logic full,
	input wire logic pop,
	output logic pop_valid,
	output cpem_pkg::op_t pop_op
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cpem_pkg::op_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = count_q == CNT_W'(DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_op = entry_q[rd_ptr_q];
	assign do_push = push_valid && !full;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("Queue count exceeds its depth.");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> count_q == $past(count_q) + 1'b1)
		else $error("Queue count missed a push.");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		!pop_valid |=> count_q <= CNT_W'(1))
		else $error("Queue grew by more than one word from empty.");

endmodule

`default_nettype wire

// ===== design/cpem_back.sv =====
// Back end: event accumulation, end-of-event bookkeeping, readout and the result register.
`timescale 1ns / 1ps
`default_nettype none

module cpem_back #(
	parameter int SLICES = 6
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [cpem_pkg::CFG_INDEX_W-1:0] cfg_index,
	input wire logic [cpem_pkg::CFG_DATA_W-1:0] cfg_data,
	input wire logic op_valid,
	input wire cpem_pkg::op_t op,
	output logic op_pop,
	output logic out_valid,
	input wire logic out_stall,
	output logic result_kind,
	output logic [31:0] event_total,
	output logic [31:0] nonempty_total,
	output logic [31:0] adc_high_total,
	output logic [31:0] pulse_total,
	output logic signed [30:0] plus_delta,
	output logic signed [30:0] minus_delta,
	output logic [28:0] peak_charge_plus,
	output logic [28:0] peak_charge_minus,
	output logic [13:0] peak_adc_plus,
	output logic [13:0] peak_adc_minus
);

	localparam int ROW_W = $clog2(SLICES);
	localparam logic signed [30:0] CHG_MAX = 31'sd536870911;
	localparam logic signed [30:0] CHG_MIN = -31'sd536870912;
	localparam logic signed [30:0] DELTA_MIN = {1'b1, 30'd0};
	localparam int FIRST_SLICE = 1;
	localparam int SECOND_SLICE = 2;

	logic [cpem_pkg::PULSE_THR_W-1:0] pulse_threshold_q;
	logic signed [29:0] sum_chg_q [SLICES][2];
	logic [13:0] sum_adc_q [SLICES][2];
	logic ev_adc_high_q;
	logic ev_has_samples_q;
	logic [28:0] peak_chg_q [SLICES][2];
	logic [13:0] peak_adc_q [SLICES][2];
	logic signed [30:0] peak_dplus_q;
	logic signed [30:0] peak_dminus_q;
	logic [31:0] cnt_q [4];
	logic out_valid_q;

	logic [ROW_W-1:0] row;
	logic signed [30:0] chg_add;
	logic signed [29:0] chg_new;
	logic [14:0] adc_add;
	logic [13:0] adc_new;
	logic signed [30:0] d_plus;
	logic signed [30:0] d_minus;
	logic pulse;
	logic [31:0] cnt_next [4];
	logic take_result;
	logic do_sample;
	logic do_close;
	logic do_read;

	function automatic logic [31:0] sat_inc(input logic [31:0] v, input logic en);
		sat_inc = (en && v != '1) ? v + 32'd1 : v;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_threshold_q <= cpem_pkg::PULSE_THRESHOLD_RESET;
		end else if (cfg_we && cfg_index == cpem_pkg::CFG_PULSE_THRESHOLD) begin
			pulse_threshold_q <= cfg_data[cpem_pkg::PULSE_THR_W-1:0];
		end
	end

	assign take_result = !out_valid_q || !out_stall;
	assign op_pop = op_valid && (op.kind == cpem_pkg::OP_SAMPLE || take_result);
	assign do_sample = op_pop && op.kind == cpem_pkg::OP_SAMPLE;
	assign do_close = op_pop && op.kind == cpem_pkg::OP_CLOSE;
	assign do_read = op_pop && op.kind == cpem_pkg::OP_READ;
	assign row = ROW_W'(op.slice);

	always_comb begin
		chg_add = {sum_chg_q[row][op.side_plus][29], sum_chg_q[row][op.side_plus]} +
			31'({{7{op.charge[23]}}, op.charge});
		if (chg_add > CHG_MAX) begin
			chg_new = CHG_MAX[29:0];
		end else if (chg_add < CHG_MIN) begin
			chg_new = CHG_MIN[29:0];
		end else begin
			chg_new = chg_add[29:0];
		end
		adc_add = {1'b0, sum_adc_q[row][op.side_plus]} + {7'd0, op.adc};
		adc_new = adc_add[14] ? 14'h3FFF : adc_add[13:0];
	end

	always_comb begin
		d_plus = {sum_chg_q[SECOND_SLICE][1][29], sum_chg_q[SECOND_SLICE][1]} -
			{sum_chg_q[FIRST_SLICE][1][29], sum_chg_q[FIRST_SLICE][1]};
		d_minus = {sum_chg_q[SECOND_SLICE][0][29], sum_chg_q[SECOND_SLICE][0]} -
			{sum_chg_q[FIRST_SLICE][0][29], sum_chg_q[FIRST_SLICE][0]};
		pulse = $signed({d_plus[30], d_plus}) > $signed({2'b00, pulse_threshold_q}) ||
			$signed({d_minus[30], d_minus}) > $signed({2'b00, pulse_threshold_q});
		cnt_next[0] = sat_inc(cnt_q[0], 1'b1);
		cnt_next[1] = sat_inc(cnt_q[1], ev_has_samples_q);
		cnt_next[2] = sat_inc(cnt_q[2], ev_adc_high_q);
		cnt_next[3] = sat_inc(cnt_q[3], pulse);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < SLICES; r++) begin
				for (int s = 0; s < 2; s++) begin
					sum_chg_q[r][s] <= '0;
					sum_adc_q[r][s] <= '0;
					peak_chg_q[r][s] <= '0;
					peak_adc_q[r][s] <= '0;
				end
			end
			ev_adc_high_q <= 1'b0;
			ev_has_samples_q <= 1'b0;
			peak_dplus_q <= DELTA_MIN;
			peak_dminus_q <= DELTA_MIN;
			for (int k = 0; k < 4; k++) begin
				cnt_q[k] <= '0;
			end
		end else if (do_sample) begin
			ev_has_samples_q <= 1'b1;
			if (op.counted) begin
				sum_chg_q[row][op.side_plus] <= chg_new;
				sum_adc_q[row][op.side_plus] <= adc_new;
				if (op.adc_high) begin
					ev_adc_high_q <= 1'b1;
				end
			end
		end else if (do_close) begin
			for (int r = 0; r < SLICES; r++) begin
				for (int s = 0; s < 2; s++) begin
					if (sum_chg_q[r][s] > $signed({1'b0, peak_chg_q[r][s]})) begin
						peak_chg_q[r][s] <= sum_chg_q[r][s][28:0];
					end
					if (sum_adc_q[r][s] > peak_adc_q[r][s]) begin
						peak_adc_q[r][s] <= sum_adc_q[r][s];
					end
					sum_chg_q[r][s] <= '0;
					sum_adc_q[r][s] <= '0;
				end
			end
			ev_adc_high_q <= 1'b0;
			ev_has_samples_q <= 1'b0;
			if (d_plus > peak_dplus_q) begin
				peak_dplus_q <= d_plus;
			end
			if (d_minus > peak_dminus_q) begin
				peak_dminus_q <= d_minus;
			end
			for (int k = 0; k < 4; k++) begin
				cnt_q[k] <= cnt_next[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_close || do_read) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_close) begin
			result_kind <= 1'b0;
			event_total <= cnt_next[0];
			nonempty_total <= cnt_next[1];
			adc_high_total <= cnt_next[2];
			pulse_total <= cnt_next[3];
			plus_delta <= d_plus;
			minus_delta <= d_minus;
			peak_charge_plus <= '0;
			peak_charge_minus <= '0;
			peak_adc_plus <= '0;
			peak_adc_minus <= '0;
		end else if (do_read) begin
			result_kind <= 1'b1;
			event_total <= cnt_q[0];
			nonempty_total <= cnt_q[1];
			adc_high_total <= cnt_q[2];
			pulse_total <= cnt_q[3];
			plus_delta <= peak_dplus_q;
			minus_delta <= peak_dminus_q;
			peak_charge_plus <= op.slice_ok ? peak_chg_q[row][1] : '0;
			peak_charge_minus <= op.slice_ok ? peak_chg_q[row][0] : '0;
			peak_adc_plus <= op.slice_ok ? peak_adc_q[row][1] : '0;
			peak_adc_minus <= op.slice_ok ? peak_adc_q[row][0] : '0;
		end
	end

	assign out_valid = out_valid_q;

	a_nonempty_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[1] <= cnt_q[0] && cnt_q[2] <= cnt_q[0] && cnt_q[3] <= cnt_q[0])
		else $error("An event counter ran ahead of the closed event count.");

	a_close_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		do_close |=> out_valid_q && !result_kind)
		else $error("End of event produced no result word.");

	a_sample_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		do_sample && !out_valid_q |=> !out_valid_q)
		else $error("A sample produced a result word.");

	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!do_close |=> cnt_q[0] == $past(cnt_q[0]))
		else $error("Event count changed without an end of event.");

endmodule

`default_nettype wire

// ===== design/calorimeter_pulse_event_monitor_top.sv =====
// Top level of the calorimeter pulse event monitor.
`timescale 1ns / 1ps
`default_nettype none

// The monitor takes one input word per clock with no bubbles while in_stall is low. A
// sample, end-of-event or readout word is classified on entry and placed in a queue of
// QUEUE_DEPTH words; the back end executes one queued word per cycle (end-of-event and
// readout words wait while a result is stalled), updating all per-slice sums and maxima
// in parallel. Results pass the queue entry and the result register. Words are taken
// while a result waits on out_stall; the queue fills only when an end-of-event or
// readout word is at its head behind a stalled result and QUEUE_DEPTH words backed up.
// The user writes thresholds via the configuration port only while idle; unchecked.
module calorimeter_pulse_event_monitor_top #(
	parameter int SLICES = 6,
	parameter int QUEUE_DEPTH = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [cpem_pkg::CFG_INDEX_W-1:0] cfg_index,
	input wire logic [cpem_pkg::CFG_DATA_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] mode,
	input wire logic side_plus,
	input wire logic [2:0] section,
	input wire logic [2:0] slice,
	input wire logic [7:0] adc,
	input wire logic signed [23:0] charge,
	output logic out_valid,
	input wire logic out_stall,
	output logic result_kind,
	output logic [31:0] event_total,
	output logic [31:0] nonempty_total,
	output logic [31:0] adc_high_total,
	output logic [31:0] pulse_total,
	output logic signed [30:0] plus_delta,
	output logic signed [30:0] minus_delta,
	output logic [28:0] peak_charge_plus,
	output logic [28:0] peak_charge_minus,
	output logic [13:0] peak_adc_plus,
	output logic [13:0] peak_adc_minus
);

	logic push_valid;
	cpem_pkg::op_t push_op;
	logic pop;
	logic pop_valid;
	cpem_pkg::op_t pop_op;

	cpem_front #(
		.SLICES(SLICES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.mode(mode),
		.side_plus(side_plus),
		.section(section),
		.slice(slice),
		.adc(adc),
		.charge(charge),
		.push_valid(push_valid),
		.push_op(push_op)
	);

	cpem_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_op(push_op),
		.full(in_stall),
		.pop(pop),
		.pop_valid(pop_valid),
		.pop_op(pop_op)
	);

	cpem_back #(
		.SLICES(SLICES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.op_valid(pop_valid),
		.op(pop_op),
		.op_pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.event_total(event_total),
		.nonempty_total(nonempty_total),
		.adc_high_total(adc_high_total),
		.pulse_total(pulse_total),
		.plus_delta(plus_delta),
		.minus_delta(minus_delta),
		.peak_charge_plus(peak_charge_plus),
		.peak_charge_minus(peak_charge_minus),
		.peak_adc_plus(peak_adc_plus),
		.peak_adc_minus(peak_adc_minus)
	);

endmodule

`default_nettype wire

// ===== sim/tb_calorimeter_pulse_event_monitor_top.sv =====
// Self-checking testbench for the calorimeter pulse event monitor, with its own event predictor.
`timescale 1ns / 1ps

module tb_calorimeter_pulse_event_monitor_top;

	localparam int SLICE_COUNT = 6;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASE_WORDS = 85;
	localparam int PHASE_COUNT = 5;
	localparam int IDLE_PCT = 34;
	localparam int BURST_ROUNDS = 66;
	localparam logic KIND_CLOSE = 1'b0;
	localparam logic KIND_READ = 1'b1;
	localparam logic [cpem_pkg::SECTION_W-1:0] SECTION_NONE = 3'd0;
	localparam logic [cpem_pkg::SECTION_W-1:0] SECTION_TOP = 3'd7;
	localparam logic signed [30:0] DELTA_FLOOR = 31'h4000_0000;
	localparam logic [cpem_pkg::PULSE_THR_W-1:0] PULSE_THR_TOP = '1;
	localparam logic signed [cpem_pkg::CHARGE_W-1:0] CHARGE_TOP = 24'h7F_FFFF;
	localparam logic signed [cpem_pkg::CHARGE_W-1:0] CHARGE_BOTTOM = 24'h80_0000;
	localparam longint CHARGE_SUM_MAX = 536870911;
	localparam longint CHARGE_SUM_MIN = -536870912;
	localparam int ADC_SUM_MAX = 16383;
	localparam int LATE_PLUS = 2 * 2 + 1;
	localparam int LATE_MINUS = 2 * 2;
	localparam int EARLY_PLUS = 1 * 2 + 1;
	localparam int EARLY_MINUS = 1 * 2;

	typedef struct {
		logic [cpem_pkg::MODE_W-1:0] mode;
		logic side_plus;
		logic [cpem_pkg::SECTION_W-1:0] section;
		logic [cpem_pkg::SLICE_W-1:0] slice;
		logic [cpem_pkg::ADC_W-1:0] adc;
		logic signed [cpem_pkg::CHARGE_W-1:0] charge;
	} cal_word_t;

	typedef struct {
		logic kind;
		logic [31:0] events;
		logic [31:0] nonempty;
		logic [31:0] adc_high;
		logic [31:0] pulses;
		logic signed [30:0] d_plus;
		logic signed [30:0] d_minus;
		logic [28:0] q_plus;
		logic [28:0] q_minus;
		logic [13:0] a_plus;
		logic [13:0] a_minus;
	} event_result_t;

	typedef struct {
		cal_word_t w;
		bit typed;
		event_result_t r;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [cpem_pkg::CFG_INDEX_W-1:0] cfg_index = cpem_pkg::CFG_ADC_THRESHOLD;
	logic [cpem_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] mode = cpem_pkg::MODE_SAMPLE;
	logic side_plus = 1'b0;
	logic [2:0] section = SECTION_NONE;
	logic [2:0] slice = '0;
	logic [7:0] adc = '0;
	logic signed [23:0] charge = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic result_kind;
	logic [31:0] event_total;
	logic [31:0] nonempty_total;
	logic [31:0] adc_high_total;
	logic [31:0] pulse_total;
	logic signed [30:0] plus_delta;
	logic signed [30:0] minus_delta;
	logic [28:0] peak_charge_plus;
	logic [28:0] peak_charge_minus;
	logic [13:0] peak_adc_plus;
	logic [13:0] peak_adc_minus;

	logic signed [29:0] ev_charge [2*SLICE_COUNT];
	logic [13:0] ev_adc [2*SLICE_COUNT];
	bit ev_adc_high;
	bit ev_nonempty;
	logic [28:0] top_charge [2*SLICE_COUNT];
	logic [13:0] top_adc [2*SLICE_COUNT];
	logic signed [30:0] top_delta_plus;
	logic signed [30:0] top_delta_minus;
	logic [31:0] n_events;
	logic [31:0] n_nonempty;
	logic [31:0] n_adc_high;
	logic [31:0] n_pulse;
	logic [cpem_pkg::ADC_W-1:0] adc_limit;
	logic [cpem_pkg::PULSE_THR_W-1:0] pulse_limit;

	event_result_t awaited_results[$];
	event_result_t blank_result;
	int mismatches = 0;
	int live_words = 0;
	int quiet_cycles = 0;
	bit steady = 1'b0;

	calorimeter_pulse_event_monitor_top dut (.*);

	always #5 clk = ~clk;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	function automatic bit track_word(input cal_word_t w, output event_result_t r);
		int ix;
		int a;
		longint sum;
		longint held;
		longint d_plus;
		longint d_minus;
		longint thr;
		if (w.mode == cpem_pkg::MODE_SAMPLE) begin
			if (w.slice < SLICE_COUNT) begin
				ev_nonempty = 1'b1;
				if (w.section == cpem_pkg::SECTION_FIRST ||
						w.section == cpem_pkg::SECTION_SECOND) begin
					ix = 2 * int'(w.slice) + int'(w.side_plus);
					sum = ev_charge[ix];
					sum += w.charge;
					if (sum > CHARGE_SUM_MAX)
						sum = CHARGE_SUM_MAX;
					else if (sum < CHARGE_SUM_MIN)
						sum = CHARGE_SUM_MIN;
					ev_charge[ix] = sum[29:0];
					a = ev_adc[ix];
					a += w.adc;
					ev_adc[ix] = (a > ADC_SUM_MAX) ? 14'(ADC_SUM_MAX) : a[13:0];
					if (w.adc > adc_limit)
						ev_adc_high = 1'b1;
				end
			end
			return 1'b0;
		end
		if (w.mode != cpem_pkg::MODE_CLOSE && w.mode != cpem_pkg::MODE_READ)
			return 1'b0;
		if (w.mode == cpem_pkg::MODE_CLOSE) begin
			d_plus = ev_charge[LATE_PLUS];
			d_plus -= ev_charge[EARLY_PLUS];
			d_minus = ev_charge[LATE_MINUS];
			d_minus -= ev_charge[EARLY_MINUS];
			thr = pulse_limit;
			n_events = sat_inc(n_events);
			if (ev_nonempty)
				n_nonempty = sat_inc(n_nonempty);
			if (ev_adc_high)
				n_adc_high = sat_inc(n_adc_high);
			if (d_plus > thr || d_minus > thr)
				n_pulse = sat_inc(n_pulse);
			if (d_plus > top_delta_plus)
				top_delta_plus = d_plus[30:0];
			if (d_minus > top_delta_minus)
				top_delta_minus = d_minus[30:0];
			for (int i = 0; i < 2 * SLICE_COUNT; i++) begin
				sum = ev_charge[i];
				held = top_charge[i];
				if (sum > held)
					top_charge[i] = sum[28:0];
				if (ev_adc[i] > top_adc[i])
					top_adc[i] = ev_adc[i];
				ev_charge[i] = '0;
				ev_adc[i] = '0;
			end
			ev_adc_high = 1'b0;
			ev_nonempty = 1'b0;
			r.kind = KIND_CLOSE;
			r.d_plus = d_plus[30:0];
			r.d_minus = d_minus[30:0];
			r.q_plus = '0;
			r.q_minus = '0;
			r.a_plus = '0;
			r.a_minus = '0;
		end else begin
			r.kind = KIND_READ;
			r.d_plus = top_delta_plus;
			r.d_minus = top_delta_minus;
			if (w.slice < SLICE_COUNT) begin
				ix = 2 * int'(w.slice);
				r.q_plus = top_charge[ix + 1];
				r.q_minus = top_charge[ix];
				r.a_plus = top_adc[ix + 1];
				r.a_minus = top_adc[ix];
			end else begin
				r.q_plus = '0;
				r.q_minus = '0;
				r.a_plus = '0;
				r.a_minus = '0;
			end
		end
		r.events = n_events;
		r.nonempty = n_nonempty;
		r.adc_high = n_adc_high;
		r.pulses = n_pulse;
		return 1'b1;
	endfunction

	function automatic cal_word_t make_word(input logic [cpem_pkg::MODE_W-1:0] m,
			input logic s, input logic [cpem_pkg::SECTION_W-1:0] sec,
			input logic [cpem_pkg::SLICE_W-1:0] sl, input logic [cpem_pkg::ADC_W-1:0] a,
			input logic signed [cpem_pkg::CHARGE_W-1:0] c);
		cal_word_t w;
		w.mode = m;
		w.side_plus = s;
		w.section = sec;
		w.slice = sl;
		w.adc = a;
		w.charge = c;
		return w;
	endfunction

	function automatic event_result_t tally(input logic k, input logic [31:0] ev,
			input logic [31:0] ne, input logic [31:0] ah, input logic [31:0] pu,
			input logic signed [30:0] dp, input logic signed [30:0] dm);
		event_result_t r;
		r.kind = k;
		r.events = ev;
		r.nonempty = ne;
		r.adc_high = ah;
		r.pulses = pu;
		r.d_plus = dp;
		r.d_minus = dm;
		r.q_plus = '0;
		r.q_minus = '0;
		r.a_plus = '0;
		r.a_minus = '0;
		return r;
	endfunction

	function automatic table_row_t row(input cal_word_t w, input bit typed, input event_result_t r);
		table_row_t t;
		t.w = w;
		t.typed = typed;
		t.r = r;
		return t;
	endfunction

	function automatic cal_word_t random_sample();
		cal_word_t w;
		int pick;
		int v;
		w.mode = cpem_pkg::MODE_SAMPLE;
		w.side_plus = 1'($urandom_range(1));
		pick = $urandom_range(99);
		if (pick < 40)
			w.section = cpem_pkg::SECTION_FIRST;
		else if (pick < 75)
			w.section = cpem_pkg::SECTION_SECOND;
		else
			w.section = 3'($urandom_range(7));
		pick = $urandom_range(99);
		if (pick < 50)
			w.slice = 3'($urandom_range(1, 2));
		else if (pick < 92)
			w.slice = 3'($urandom_range(SLICE_COUNT - 1));
		else
			w.slice = 3'($urandom_range(7, SLICE_COUNT));
		if ($urandom_range(99) < 50) begin
			w.adc = 8'($urandom_range(255));
		end else begin
			v = int'(adc_limit) + int'($urandom_range(4)) - 2;
			if (v < 0)
				v = 0;
			if (v > 255)
				v = 255;
			w.adc = v[7:0];
		end
		pick = $urandom_range(99);
		if (pick < 55) begin
			v = int'($urandom_range(600)) - 300;
			w.charge = v[23:0];
		end else if (pick < 85) begin
			w.charge = 24'($urandom);
		end else begin
			w.charge = $urandom_range(1) ? CHARGE_TOP : CHARGE_BOTTOM;
		end
		return w;
	endfunction

	task automatic send_word(input cal_word_t w, input bit typed, input event_result_t typed_r);
		event_result_t r;
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= w.mode;
		side_plus <= w.side_plus;
		section <= w.section;
		slice <= w.slice;
		adc <= w.adc;
		charge <= w.charge;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (track_word(w, r)) begin
			if (typed)
				awaited_results.push_back(typed_r);
			else
				awaited_results.push_back(r);
		end
		if (!(w.mode == cpem_pkg::MODE_UNUSED ||
				(w.mode == cpem_pkg::MODE_SAMPLE && w.slice >= SLICE_COUNT)))
			live_words++;
	endtask

	task automatic random_event();
		cal_word_t w;
		int n;
		n = $urandom_range(10);
		repeat (n) begin
			send_word(random_sample(), 1'b0, blank_result);
			if ($urandom_range(99) < 3) begin
				w = random_sample();
				w.mode = cpem_pkg::MODE_UNUSED;
				send_word(w, 1'b0, blank_result);
			end
		end
		// An event is occasionally left open so that it runs into the next one.
		if ($urandom_range(99) < 94) begin
			w = random_sample();
			w.mode = cpem_pkg::MODE_CLOSE;
			send_word(w, 1'b0, blank_result);
		end
		if ($urandom_range(99) < 25) begin
			w = random_sample();
			w.mode = cpem_pkg::MODE_READ;
			w.slice = 3'($urandom_range(7));
			send_word(w, 1'b0, blank_result);
		end
	endtask

	// Drives the slice 2 sum to its upper bound and the slice 1 sum to its lower one.
	task automatic saturate_side(input logic s);
		repeat (BURST_ROUNDS) begin
			send_word(make_word(cpem_pkg::MODE_SAMPLE, s, cpem_pkg::SECTION_FIRST, 3'd2, 8'd255,
				CHARGE_TOP), 1'b0, blank_result);
			send_word(make_word(cpem_pkg::MODE_SAMPLE, s, cpem_pkg::SECTION_SECOND, 3'd1, 8'd255,
				CHARGE_BOTTOM), 1'b0, blank_result);
		end
		send_word(make_word(cpem_pkg::MODE_CLOSE, s, SECTION_NONE, 3'd0, 8'd0, 24'sd0), 1'b0,
			blank_result);
		send_word(make_word(cpem_pkg::MODE_READ, s, SECTION_NONE, 3'd2, 8'd0, 24'sd0), 1'b0,
			blank_result);
		send_word(make_word(cpem_pkg::MODE_READ, s, SECTION_NONE, 3'd1, 8'd0, 24'sd0), 1'b0,
			blank_result);
	endtask

	task automatic write_thresholds(input logic [cpem_pkg::ADC_W-1:0] a,
			input logic [cpem_pkg::PULSE_THR_W-1:0] p);
		cfg_we <= 1'b1;
		cfg_index <= cpem_pkg::CFG_ADC_THRESHOLD;
		cfg_data <= cpem_pkg::CFG_DATA_W'(a);
		@(posedge clk);
		cfg_index <= cpem_pkg::CFG_PULSE_THRESHOLD;
		cfg_data <= p;
		@(posedge clk);
		cfg_we <= 1'b0;
		adc_limit = a;
		pulse_limit = p;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) begin : result_check
		event_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				$error("result word arrived with none expected");
				mismatches++;
			end else begin
				want = awaited_results.pop_front();
				check_field("result_kind", want.kind, result_kind);
				check_field("event_total", want.events, event_total);
				check_field("nonempty_total", want.nonempty, nonempty_total);
				check_field("adc_high_total", want.adc_high, adc_high_total);
				check_field("pulse_total", want.pulses, pulse_total);
				check_field("plus_delta", want.d_plus, plus_delta);
				check_field("minus_delta", want.d_minus, minus_delta);
				check_field("peak_charge_plus", want.q_plus, peak_charge_plus);
				check_field("peak_charge_minus", want.q_minus, peak_charge_minus);
				check_field("peak_adc_plus", want.a_plus, peak_adc_plus);
				check_field("peak_adc_minus", want.a_minus, peak_adc_minus);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_calorimeter_pulse_event_monitor_top NOT OK");
			$finish;
		end
	end

	initial begin : run
		table_row_t rows[$];
		int phase_start;
		blank_result = tally(KIND_CLOSE, 0, 0, 0, 0, 31'sd0, 31'sd0);
		for (int i = 0; i < 2 * SLICE_COUNT; i++) begin
			ev_charge[i] = '0;
			ev_adc[i] = '0;
			top_charge[i] = '0;
			top_adc[i] = '0;
		end
		ev_adc_high = 1'b0;
		ev_nonempty = 1'b0;
		top_delta_plus = DELTA_FLOOR;
		top_delta_minus = DELTA_FLOOR;
		n_events = '0;
		n_nonempty = '0;
		n_adc_high = '0;
		n_pulse = '0;
		adc_limit = cpem_pkg::ADC_THRESHOLD_RESET;
		pulse_limit = cpem_pkg::PULSE_THRESHOLD_RESET;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows.push_back(row(make_word(cpem_pkg::MODE_READ, 1'b0, SECTION_NONE, 3'd0, 8'd0,
			24'sd0), 1'b1, tally(KIND_READ, 0, 0, 0, 0, DELTA_FLOOR, DELTA_FLOOR)));
		rows.push_back(row(make_word(cpem_pkg::MODE_READ, 1'b1, SECTION_TOP, 3'd7, 8'd255,
			CHARGE_TOP), 1'b1, tally(KIND_READ, 0, 0, 0, 0, DELTA_FLOOR, DELTA_FLOOR)));
		rows.push_back(row(make_word(cpem_pkg::MODE_UNUSED, 1'b1, cpem_pkg::SECTION_FIRST, 3'd2,
			8'd255, CHARGE_TOP), 1'b0, blank_result));
		rows.push_back(row(make_word(cpem_pkg::MODE_SAMPLE, 1'b1, cpem_pkg::SECTION_FIRST, 3'd6,
			8'd255, CHARGE_TOP), 1'b0, blank_result));
		rows.push_back(row(make_word(cpem_pkg::MODE_SAMPLE, 1'b0, cpem_pkg::SECTION_SECOND, 3'd7,
			8'd255, CHARGE_BOTTOM), 1'b0, blank_result));
		rows.push_back(row(make_word(cpem_pkg::MODE_CLOSE, 1'b0, SECTION_NONE, 3'd0, 8'd0,
			24'sd0), 1'b1, tally(KIND_CLOSE, 1, 0, 0, 0, 31'sd0, 31'sd0)));
		rows.push_back(row(make_word(cpem_pkg::MODE_SAMPLE, 1'b1, SECTION_NONE, 3'd2, 8'd255,
			CHARGE_TOP), 1'b0, blank_result));
		rows.push_back(row(make_word(cpem_pkg::MODE_SAMPLE, 1'b0, SECTION_TOP, 3'd1, 8'd255,
			CHARGE_BOTTOM), 1'b0, blank_result));
		rows.push_back(row(make_word(cpem_pkg::MODE_CLOSE, 1'b0, SECTION_NONE, 3'd0, 8'd0,
			24'sd0), 1'b1, tally(KIND_CLOSE, 2, 1, 0, 0, 31'sd0, 31'sd0)));
		rows.push_back(row(make_word(cpem_pkg::MODE_SAMPLE, 1'b1, cpem_pkg::SECTION_FIRST, 3'd2,
			8'd10, 24'sd161), 1'b0, blank_result));
		rows.push_back(row(make_word(cpem_pkg::MODE_CLOSE, 1'b0, SECTION_NONE, 3'd0, 8'd0,
			24'sd0), 1'b1, tally(KIND_CLOSE, 3, 2, 0, 1, 31'sd161, 31'sd0)));
		rows.push_back(row(make_word(cpem_pkg::MODE_SAMPLE, 1'b0, cpem_pkg::SECTION_SECOND, 3'd1,
			8'd11, CHARGE_BOTTOM), 1'b0, blank_result));
		rows.push_back(row(make_word(cpem_pkg::MODE_SAMPLE, 1'b0, cpem_pkg::SECTION_FIRST, 3'd2,
			8'd0, CHARGE_TOP), 1'b0, blank_result));
		rows.push_back(row(make_word(cpem_pkg::MODE_CLOSE, 1'b0, SECTION_NONE, 3'd0, 8'd0,
			24'sd0), 1'b1, tally(KIND_CLOSE, 4, 3, 1, 2, 31'sd0, 31'sd16777215)));
		rows.push_back(row(make_word(cpem_pkg::MODE_SAMPLE, 1'b1, cpem_pkg::SECTION_SECOND, 3'd2,
			8'd255, 24'sd160), 1'b0, blank_result));
		rows.push_back(row(make_word(cpem_pkg::MODE_SAMPLE, 1'b0, cpem_pkg::SECTION_FIRST, 3'd0,
			8'd255, -24'sd1), 1'b0, blank_result));
		rows.push_back(row(make_word(cpem_pkg::MODE_SAMPLE, 1'b1, cpem_pkg::SECTION_SECOND, 3'd5,
			8'd200, 24'sd5000), 1'b0, blank_result));
		rows.push_back(row(make_word(cpem_pkg::MODE_CLOSE, 1'b0, SECTION_NONE, 3'd0, 8'd0,
			24'sd0), 1'b1, tally(KIND_CLOSE, 5, 4, 2, 2, 31'sd160, 31'sd0)));
		rows.push_back(row(make_word(cpem_pkg::MODE_READ, 1'b0, SECTION_NONE, 3'd2, 8'd0,
			24'sd0), 1'b0, blank_result));
		rows.push_back(row(make_word(cpem_pkg::MODE_READ, 1'b0, SECTION_NONE, 3'd1, 8'd0,
			24'sd0), 1'b0, blank_result));
		rows.push_back(row(make_word(cpem_pkg::MODE_READ, 1'b0, SECTION_NONE, 3'd0, 8'd0,
			24'sd0), 1'b0, blank_result));
		rows.push_back(row(make_word(cpem_pkg::MODE_READ, 1'b0, SECTION_NONE, 3'd5, 8'd0,
			24'sd0), 1'b0, blank_result));
		rows.push_back(row(make_word(cpem_pkg::MODE_READ, 1'b0, SECTION_NONE, 3'd6, 8'd0,
			24'sd0), 1'b1, tally(KIND_READ, 5, 4, 2, 2, 31'sd161, 31'sd16777215)));
		foreach (rows[i])
			send_word(rows[i].w, rows[i].typed, rows[i].r);

		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			settle();
			if (ph == 0)
				write_thresholds('0, '0);
			else if (ph == 1)
				write_thresholds('1, PULSE_THR_TOP);
			else
				write_thresholds(8'($urandom_range(255)),
					($urandom_range(3) == 0) ? 30'($urandom) : 30'($urandom_range(600)));
			steady = (ph == 2);
			if (ph == 1)
				saturate_side(1'b1);
			if (ph == 3)
				saturate_side(1'b0);
			phase_start = live_words;
			while (live_words - phase_start < PHASE_WORDS)
				random_event();
		end
		settle();

		if (mismatches == 0)
			$display("tb_calorimeter_pulse_event_monitor_top OK");
		else
			$display("tb_calorimeter_pulse_event_monitor_top NOT OK");
		$finish;
	end

endmodule
